// File: hdl/ssx_pkg.sv
// ----------------------------------------------------------------------------
// ssx_pkg: shared types and constants of the smoothed sample extremes tracker
// Fixed-point formats, register indexes and the result record.
// ----------------------------------------------------------------------------
package ssx_pkg;

  localparam int SampleBits = 12;
  localparam int FracBits   = 8;
  localparam int ValBits    = SampleBits + FracBits;
  localparam int CountBits  = 16;
  localparam int TimeBits   = 32;
  localparam int WeightBits = 9;
  localparam int WeightFrac = 8;
  localparam int RegBits    = 20;
  localparam int CfgIdxBits = 2;

  localparam logic [WeightBits-1:0] WeightOne      = WeightBits'(1 << WeightFrac);
  localparam logic [WeightBits-1:0] WeightReset    = WeightBits'(230);
  localparam logic [RegBits-1:0]    HighThrReset   = RegBits'(943718);
  localparam logic [RegBits-1:0]    LowThrReset    = RegBits'(104832);

  localparam int InDataBits  = ((SampleBits + TimeBits + 7) / 8) * 8;
  localparam int OutUsedBits = 3 * RegBits + 2 * CountBits + 4 * TimeBits;
  localparam int OutDataBits = ((OutUsedBits + 7) / 8) * 8;

  typedef enum logic [CfgIdxBits-1:0] {
    CfgWeight  = 2'd0,
    CfgHighThr = 2'd1,
    CfgLowThr  = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [TimeBits-1:0]  trough_ms;
    logic [RegBits-1:0]   trough_value;
    logic [TimeBits-1:0]  peak_ms;
    logic [RegBits-1:0]   peak_value;
    logic [TimeBits-1:0]  last_low_ms;
    logic [TimeBits-1:0]  last_high_ms;
    logic [CountBits-1:0] low_hits;
    logic [CountBits-1:0] high_hits;
    logic [RegBits-1:0]   filtered;
  } result_t;

endpackage

// File: hdl/ssx_in_stage.sv
// ----------------------------------------------------------------------------
// ssx_in_stage: input word register
// Captures one sample word and holds it until the tracker takes it.
// ----------------------------------------------------------------------------
module ssx_in_stage (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  output logic                          ready_o,
  input  logic [ssx_pkg::SampleBits-1:0] sample_i,
  input  logic [ssx_pkg::TimeBits-1:0]   time_i,
  output logic                          valid_o,
  input  logic                          take_i,
  output logic [ssx_pkg::SampleBits-1:0] sample_o,
  output logic [ssx_pkg::TimeBits-1:0]   time_o
);
  import ssx_pkg::*;

  logic                  valid_q, valid_d;
  logic                  load;
  logic [SampleBits-1:0] sample_q;
  logic [TimeBits-1:0]   time_q;

  assign ready_o = !valid_q || take_i;
  assign load    = valid_i && ready_o;
  assign valid_d = load || (valid_q && !take_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      sample_q <= sample_i;
      time_q   <= time_i;
    end
  end

  assign valid_o  = valid_q;
  assign sample_o = sample_q;
  assign time_o   = time_q;

endmodule

// File: hdl/ssx_filter.sv
// ----------------------------------------------------------------------------
// ssx_filter: first-order exponential smoothing
// f = s + (w * (x - s) + 0.5) in Q1.8 weight, rounded half up.
// ----------------------------------------------------------------------------
module ssx_filter (
  input  logic [ssx_pkg::SampleBits-1:0] sample_i,
  input  logic [ssx_pkg::ValBits-1:0]    smoothed_i,
  input  logic [ssx_pkg::WeightBits-1:0] weight_i,
  output logic [ssx_pkg::ValBits-1:0]    filtered_o
);
  import ssx_pkg::*;

  localparam int AccBits = ValBits + WeightFrac + 3;

  logic [WeightBits-1:0]     w_sat;
  logic [ValBits-1:0]        x;
  logic signed [ValBits:0]   diff;
  logic signed [AccBits-1:0] prod;
  logic signed [AccBits-1:0] acc;

  always_comb begin
    w_sat = (weight_i > WeightOne) ? WeightOne : weight_i;
    x     = {sample_i, FracBits'(0)};
    diff  = $signed({1'b0, x}) - $signed({1'b0, smoothed_i});
    prod  = AccBits'($signed({1'b0, w_sat}) * diff);
    acc   = prod
          + $signed(AccBits'({smoothed_i, WeightFrac'(0)}))
          + $signed(AccBits'(1 << (WeightFrac - 1)));
  end

  assign filtered_o = acc[ValBits+WeightFrac-1:WeightFrac];

endmodule

// File: hdl/ssx_tracker.sv
// ----------------------------------------------------------------------------
// ssx_tracker: filter state, hit counters and extremes
// Updates all tracked values per word; the state doubles as result register.
// ----------------------------------------------------------------------------
module ssx_tracker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  output logic                          take_o,
  input  logic [ssx_pkg::SampleBits-1:0] sample_i,
  input  logic [ssx_pkg::TimeBits-1:0]   time_i,
  input  logic [ssx_pkg::WeightBits-1:0] weight_i,
  input  logic [ssx_pkg::RegBits-1:0]    high_thr_i,
  input  logic [ssx_pkg::RegBits-1:0]    low_thr_i,
  output logic                          valid_o,
  input  logic                          ready_i,
  output ssx_pkg::result_t              result_o
);
  import ssx_pkg::*;

  logic                 valid_q, valid_d;
  logic [ValBits-1:0]   smoothed_q, f;
  logic [CountBits-1:0] high_cnt_q, high_cnt_d, low_cnt_q, low_cnt_d;
  logic [TimeBits-1:0]  high_ms_q, high_ms_d, low_ms_q, low_ms_d;
  logic [ValBits-1:0]   max_q, max_d, min_q, min_d;
  logic [TimeBits-1:0]  max_ms_q, max_ms_d, min_ms_q, min_ms_d;
  logic                 hit_high, hit_low;

  ssx_filter u_filter (
    .sample_i  (sample_i),
    .smoothed_i(smoothed_q),
    .weight_i  (weight_i),
    .filtered_o(f)
  );

  assign take_o  = valid_i && (!valid_q || ready_i);
  assign valid_d = take_o || (valid_q && !ready_i);

  always_comb begin
    hit_high   = RegBits'(f) > high_thr_i;
    hit_low    = RegBits'(f) < low_thr_i;
    high_cnt_d = high_cnt_q;
    high_ms_d  = high_ms_q;
    low_cnt_d  = low_cnt_q;
    low_ms_d   = low_ms_q;
    max_d      = max_q;
    max_ms_d   = max_ms_q;
    min_d      = min_q;
    min_ms_d   = min_ms_q;
    if (hit_high) begin
      high_cnt_d = (&high_cnt_q) ? high_cnt_q : high_cnt_q + 1'b1;
      high_ms_d  = time_i;
    end
    if (hit_low) begin
      low_cnt_d = (&low_cnt_q) ? low_cnt_q : low_cnt_q + 1'b1;
      low_ms_d  = time_i;
    end
    if (f > max_q) begin
      max_d    = f;
      max_ms_d = time_i;
    end
    if (f < min_q) begin
      min_d    = f;
      min_ms_d = time_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= 1'b0;
      smoothed_q <= '0;
      high_cnt_q <= '0;
      low_cnt_q  <= '0;
      high_ms_q  <= '0;
      low_ms_q   <= '0;
      max_q      <= '0;
      max_ms_q   <= '0;
      min_q      <= '1;
      min_ms_q   <= '0;
    end else begin
      valid_q <= valid_d;
      if (take_o) begin
        smoothed_q <= f;
        high_cnt_q <= high_cnt_d;
        low_cnt_q  <= low_cnt_d;
        high_ms_q  <= high_ms_d;
        low_ms_q   <= low_ms_d;
        max_q      <= max_d;
        max_ms_q   <= max_ms_d;
        min_q      <= min_d;
        min_ms_q   <= min_ms_d;
      end
    end
  end

  assign valid_o               = valid_q;
  assign result_o.filtered     = RegBits'(smoothed_q);
  assign result_o.high_hits    = high_cnt_q;
  assign result_o.low_hits     = low_cnt_q;
  assign result_o.last_high_ms = high_ms_q;
  assign result_o.last_low_ms  = low_ms_q;
  assign result_o.peak_value   = RegBits'(max_q);
  assign result_o.peak_ms      = max_ms_q;
  assign result_o.trough_value = RegBits'(min_q);
  assign result_o.trough_ms    = min_ms_q;

endmodule

// File: hdl/smoothed_sample_extremes_tracker_core.sv
// ----------------------------------------------------------------------------
// smoothed_sample_extremes_tracker_core: smoothed ADC extremes tracker
// Path: input stage register, then result register. Throughput: one word per cycle
//   unless m_axis_tready stalls; the filter multiply-add and the threshold and
//   extreme compares settle combinationally between input and result register.
// Reset: clears filter state, counters, time stamps and extremes (trough to
//   all ones) and loads the configuration registers with their defaults.
// ----------------------------------------------------------------------------
module smoothed_sample_extremes_tracker_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // sample[11:0], time_ms[43:12], zero pad
  input  logic [ssx_pkg::InDataBits-1:0]  s_axis_tdata,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // filtered, high_hits, low_hits, last_high_ms, last_low_ms,
  // peak_value, peak_ms, trough_value, trough_ms, zero pad
  output logic [ssx_pkg::OutDataBits-1:0] m_axis_tdata,
  input  logic                           cfg_we_i,
  input  logic [ssx_pkg::CfgIdxBits-1:0]  cfg_addr_i,
  input  logic [ssx_pkg::RegBits-1:0]     cfg_wdata_i
);
  import ssx_pkg::*;

  logic [WeightBits-1:0] weight_q;
  logic [RegBits-1:0]    high_thr_q, low_thr_q;
  logic                  st_valid, take;
  logic [SampleBits-1:0] st_sample;
  logic [TimeBits-1:0]   st_time;
  result_t               result;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      weight_q   <= WeightReset;
      high_thr_q <= HighThrReset;
      low_thr_q  <= LowThrReset;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        CfgWeight:  weight_q   <= cfg_wdata_i[WeightBits-1:0];
        CfgHighThr: high_thr_q <= cfg_wdata_i;
        CfgLowThr:  low_thr_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  ssx_in_stage u_in_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .sample_i(s_axis_tdata[SampleBits-1:0]),
    .time_i  (s_axis_tdata[SampleBits+TimeBits-1:SampleBits]),
    .valid_o (st_valid),
    .take_i  (take),
    .sample_o(st_sample),
    .time_o  (st_time)
  );

  ssx_tracker u_tracker (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (st_valid),
    .take_o    (take),
    .sample_i  (st_sample),
    .time_i    (st_time),
    .weight_i  (weight_q),
    .high_thr_i(high_thr_q),
    .low_thr_i (low_thr_q),
    .valid_o   (m_axis_tvalid),
    .ready_i   (m_axis_tready),
    .result_o  (result)
  );

  assign m_axis_tdata = OutDataBits'(result);

endmodule

// File: tb/sv/smoothed_sample_extremes_tracker_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smoothed_sample_extremes_tracker_core_tb: self-checking stream testbench
// Drives ADC sample words with time stamps into the tracker and checks each
// result word against an in-bench filter and extremes predictor. The run
// covers directed edge cases, randomized phases under several register
// settings with bursty idling on both stream sides, a long receiver hold-off,
// a sender pause until drained, and a final gap-free pass that hits both
// thresholds on every word.
// ----------------------------------------------------------------------------
module smoothed_sample_extremes_tracker_core_tb;
  import ssx_pkg::*;

  localparam logic [CfgIdxBits-1:0] CfgUnused = 2'd3;
  localparam logic [RegBits-1:0]    RegMax    = '1;
  localparam logic [RegBits-1:0]    FullScale = RegBits'(((1 << SampleBits) - 1) << FracBits);
  localparam int                    Limit     = 1_000_000;
  localparam int                    HoldCycles = 300;
  localparam int                    Phases    = 8;
  localparam int                    PhaseItems = 235;
  localparam int                    SatItems  = 24;
  localparam int                    MaxReports = 200;

  class tracker_scoreboard;
    logic [WeightBits-1:0] weight;
    logic [RegBits-1:0]    hi_thr;
    logic [RegBits-1:0]    lo_thr;
    logic [ValBits-1:0]    level;
    logic [CountBits-1:0]  hi_cnt;
    logic [CountBits-1:0]  lo_cnt;
    logic [TimeBits-1:0]   hi_ms;
    logic [TimeBits-1:0]   lo_ms;
    logic [ValBits-1:0]    peak;
    logic [TimeBits-1:0]   peak_ms;
    logic [ValBits-1:0]    trough;
    logic [TimeBits-1:0]   trough_ms;
    result_t               pending[$];
    int                    errors;
    int                    checked;

    function new();
      weight    = WeightReset;
      hi_thr    = HighThrReset;
      lo_thr    = LowThrReset;
      level     = '0;
      hi_cnt    = '0;
      lo_cnt    = '0;
      hi_ms     = '0;
      lo_ms     = '0;
      peak      = '0;
      peak_ms   = '0;
      trough    = '1;
      trough_ms = '0;
      errors    = 0;
      checked   = 0;
    endfunction

    function void write_reg(logic [CfgIdxBits-1:0] idx, logic [RegBits-1:0] val);
      case (idx)
        CfgWeight:  weight = val[WeightBits-1:0];
        CfgHighThr: hi_thr = val;
        CfgLowThr:  lo_thr = val;
        default: ;
      endcase
    endfunction

    function void note_sample(logic [SampleBits-1:0] smp, logic [TimeBits-1:0] t);
      logic [63:0] x;
      logic [63:0] w;
      logic [63:0] acc;
      result_t     r;
      x = 64'(smp) << FracBits;
      w = (weight > WeightOne) ? 64'(WeightOne) : 64'(weight);
      acc = (w * x + (64'(WeightOne) - w) * 64'(level) + 64'(WeightOne >> 1)) >> WeightFrac;
      level = acc[ValBits-1:0];
      if (level > hi_thr) begin
        if (hi_cnt != '1) hi_cnt = hi_cnt + 1'b1;
        hi_ms = t;
      end
      if (level < lo_thr) begin
        if (lo_cnt != '1) lo_cnt = lo_cnt + 1'b1;
        lo_ms = t;
      end
      if (level > peak) begin
        peak    = level;
        peak_ms = t;
      end
      if (level < trough) begin
        trough    = level;
        trough_ms = t;
      end
      r.filtered     = level;
      r.high_hits    = hi_cnt;
      r.low_hits     = lo_cnt;
      r.last_high_ms = hi_ms;
      r.last_low_ms  = lo_ms;
      r.peak_value   = peak;
      r.peak_ms      = peak_ms;
      r.trough_value = trough;
      r.trough_ms    = trough_ms;
      pending.push_back(r);
    endfunction

    function void cmp(string name, logic [TimeBits-1:0] want, logic [TimeBits-1:0] got);
      if (want !== got) begin
        errors++;
        if (errors <= MaxReports)
          $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
      end
    endfunction

    function void check_word(result_t got);
      result_t want;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= MaxReports)
          $display("%0t: unexpected result word, expected none actual %h", $time, got);
        return;
      end
      want = pending.pop_front();
      checked++;
      cmp("filtered", want.filtered, got.filtered);
      cmp("high_hits", want.high_hits, got.high_hits);
      cmp("low_hits", want.low_hits, got.low_hits);
      cmp("last_high_ms", want.last_high_ms, got.last_high_ms);
      cmp("last_low_ms", want.last_low_ms, got.last_low_ms);
      cmp("peak_value", want.peak_value, got.peak_value);
      cmp("peak_ms", want.peak_ms, got.peak_ms);
      cmp("trough_value", want.trough_value, got.trough_value);
      cmp("trough_ms", want.trough_ms, got.trough_ms);
    endfunction
  endclass

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_valid = 1'b0;
  logic                   s_axis_tready;
  logic [InDataBits-1:0]  s_data = '0;
  logic                   m_axis_tvalid;
  logic                   m_ready = 1'b0;
  logic [OutDataBits-1:0] m_axis_tdata;
  logic                   cfg_we = 1'b0;
  logic [CfgIdxBits-1:0]  cfg_addr = '0;
  logic [RegBits-1:0]     cfg_wdata = '0;

  tracker_scoreboard      sb = new();
  bit                     idle_on = 1'b0;
  bit                     hold_sink = 1'b0;
  int                     cycle_count = 0;
  int                     settings_seen = 1;
  logic [TimeBits-1:0]    t_now = '0;
  logic [SampleBits-1:0]  last_sample = '0;

  smoothed_sample_extremes_tracker_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_data),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we),
    .cfg_addr_i    (cfg_addr),
    .cfg_wdata_i   (cfg_wdata)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= Limit) begin
      $display("smoothed_sample_extremes_tracker_core test failed");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_ready)
      sb.check_word(result_t'(m_axis_tdata[$bits(result_t)-1:0]));
  end

  initial begin : sink_proc
    int n;
    wait (rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_sink) begin
        m_ready <= 1'b0;
        repeat (HoldCycles - 1) @(negedge clk_i);
        hold_sink = 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        n = $urandom_range(1, 9);
        m_ready <= 1'b0;
        repeat (n - 1) @(negedge clk_i);
      end else begin
        m_ready <= 1'b1;
      end
    end
  end

  task automatic send_word(logic [SampleBits-1:0] smp, logic [TimeBits-1:0] t);
    @(negedge clk_i);
    s_valid <= 1'b1;
    s_data  <= InDataBits'({t, smp});
    forever begin
      @(posedge clk_i);
      if (s_axis_tready) break;
    end
    sb.note_sample(smp, t);
    last_sample = smp;
  endtask

  task automatic sender_gap();
    int n;
    n = $urandom_range(1, 9);
    @(negedge clk_i);
    s_valid <= 1'b0;
    repeat (n - 1) @(negedge clk_i);
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    s_valid <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxBits-1:0] idx, logic [RegBits-1:0] val);
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(negedge clk_i);
    cfg_we <= 1'b0;
    sb.write_reg(idx, val);
  endtask

  // weight writes carry junk above the 9-bit field
  task automatic write_weight(logic [WeightBits-1:0] w);
    logic [RegBits-1:0] val;
    val = RegBits'($urandom) & ~RegBits'((1 << WeightBits) - 1);
    write_reg(CfgWeight, val | RegBits'(w));
    settings_seen++;
  endtask

  function automatic logic [SampleBits-1:0] pick_sample(int mode);
    logic [SampleBits-1:0] s;
    int                    d;
    case (mode)
      0: s = SampleBits'($urandom);
      1: begin
        case ($urandom_range(0, 3))
          0: s = '0;
          1: s = '1;
          2: s = SampleBits'(1);
          default: s = SampleBits'((1 << SampleBits) - 2);
        endcase
      end
      2: begin
        d = int'(last_sample) + $urandom_range(0, 64) - 32;
        if (d < 0) d = 0;
        if (d > (1 << SampleBits) - 1) d = (1 << SampleBits) - 1;
        s = SampleBits'(d);
      end
      default: begin
        d = int'(($urandom_range(0, 1) ? sb.hi_thr : sb.lo_thr) >> FracBits)
            + $urandom_range(0, 2) - 1;
        if (d < 0) d = 0;
        if (d > (1 << SampleBits) - 1) d = (1 << SampleBits) - 1;
        s = SampleBits'(d);
      end
    endcase
    return s;
  endfunction

  function automatic logic [TimeBits-1:0] pick_time();
    if ($urandom_range(0, 3) == 0) t_now = TimeBits'($urandom);
    else t_now = t_now + TimeBits'($urandom_range(0, 5));
    return t_now;
  endfunction

  initial begin : stim_proc
    int                  p;
    int                  i;
    int                  mode;
    int                  wait_cycles;
    logic [WeightBits-1:0] w;

    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(negedge clk_i);

    idle_on = 1'b1;
    send_word('0, '0);
    send_word('1, '1);
    send_word('1, TimeBits'(1));
    send_word('0, TimeBits'(32'h8000_0000));
    drain_results();
    write_weight(WeightOne);
    write_reg(CfgHighThr, FullScale);
    send_word('1, TimeBits'(10));
    send_word('1, TimeBits'(11));
    drain_results();
    write_reg(CfgHighThr, FullScale - 1'b1);
    send_word('1, TimeBits'(12));
    drain_results();
    write_reg(CfgLowThr, '0);
    send_word('0, TimeBits'(13));
    drain_results();
    write_reg(CfgLowThr, RegBits'(1));
    send_word('0, TimeBits'(14));
    drain_results();
    write_weight('1);
    send_word(SampleBits'(2048), TimeBits'(15));
    drain_results();
    write_weight('0);
    send_word('1, TimeBits'(16));
    send_word('0, TimeBits'(17));
    drain_results();
    write_weight(WeightBits'(1));
    send_word('1, TimeBits'(18));
    drain_results();
    write_reg(CfgUnused, RegMax);
    send_word(SampleBits'(1234), TimeBits'(19));
    drain_results();
    write_reg(CfgHighThr, RegMax);
    write_reg(CfgLowThr, RegMax);
    send_word('1, TimeBits'(20));
    drain_results();

    for (p = 0; p < Phases; p++) begin
      drain_results();
      case (p)
        0: w = WeightOne;
        1: w = WeightReset;
        2: w = WeightBits'(1);
        3: w = WeightBits'(511);
        4: w = WeightBits'(128);
        5: w = WeightBits'($urandom_range(0, 511));
        6: w = WeightBits'(255);
        default: w = WeightBits'(300);
      endcase
      write_weight(w);
      case (p)
        0: begin
          write_reg(CfgHighThr, '0);
          write_reg(CfgLowThr, RegMax);
        end
        2: begin
          write_reg(CfgHighThr, RegMax);
          write_reg(CfgLowThr, '0);
        end
        default: begin
          write_reg(CfgHighThr, RegBits'($urandom_range(0, (1 << RegBits) - 1)));
          write_reg(CfgLowThr, RegBits'($urandom_range(0, (1 << RegBits) - 1)));
        end
      endcase
      idle_on = (p != Phases - 1);
      for (i = 0; i < PhaseItems; i++) begin
        if (p == 2 && i == 20) begin
          hold_sink = 1'b1;
          repeat (40) begin
            send_word(pick_sample(0), pick_time());
          end
          wait (!hold_sink);
        end
        if (p == 3 && i == PhaseItems / 2) drain_results();
        if (idle_on && $urandom_range(0, 5) == 0) sender_gap();
        mode = $urandom_range(0, 9);
        mode = (mode < 4) ? 0 : (mode < 5) ? 1 : (mode < 8) ? 2 : 3;
        send_word(pick_sample(mode), pick_time());
      end
    end

    // hit both thresholds on every word, back to back
    drain_results();
    idle_on = 1'b0;
    write_weight(WeightOne);
    write_reg(CfgHighThr, '0);
    write_reg(CfgLowThr, RegMax);
    for (i = 0; i < SatItems; i++) begin
      t_now = t_now + 1'b1;
      send_word(SampleBits'($urandom_range(1, (1 << SampleBits) - 1)), t_now);
    end

    @(negedge clk_i);
    s_valid <= 1'b0;
    wait_cycles = 0;
    while (sb.pending.size() != 0 && wait_cycles < 2000) begin
      @(negedge clk_i);
      wait_cycles++;
    end
    repeat (10) @(negedge clk_i);
    if (sb.pending.size() != 0) begin
      sb.errors++;
      $display("%0t: %0d expected result words never arrived", $time, sb.pending.size());
    end

    $display("Checked %0d result words across %0d weight settings plus threshold extremes,",
             sb.checked, settings_seen);
    $display("with stream stalls, a long output hold-off and a gap-free double-hit pass.");
    if (sb.errors == 0) begin
      $display("smoothed_sample_extremes_tracker_core test passed");
    end else begin
      $display("smoothed_sample_extremes_tracker_core test failed");
    end
    $finish;
  end

endmodule

// File: files.f
hdl/ssx_pkg.sv
hdl/ssx_in_stage.sv
hdl/ssx_filter.sv
hdl/ssx_tracker.sv
hdl/smoothed_sample_extremes_tracker_core.sv
tb/sv/smoothed_sample_extremes_tracker_core_tb.sv
